// File: sv/sfrt_pkg.sv
package sfrt_pkg;

  localparam int DEF_RULE_DEPTH = 64;
  localparam int NUM_PERSONALITIES = 8;

  localparam logic [2:0] VERDICT_ALLOW = 3'd0;
  localparam logic [2:0] VERDICT_DENY  = 3'd1;
  localparam logic [2:0] VERDICT_ERRNO = 3'd2;
  localparam logic [2:0] VERDICT_ADDED = 3'd3;
  localparam logic [2:0] VERDICT_FULL  = 3'd4;

  localparam logic [15:0] KIND_KILL_PROC = 16'h8000;
  localparam logic [15:0] KIND_KILL_THR  = 16'h0000;
  localparam logic [15:0] KIND_TRAP      = 16'h0003;
  localparam logic [15:0] KIND_ERRNO     = 16'h0005;
  localparam logic [15:0] KIND_TRACE     = 16'h7FF0;
  localparam logic [15:0] KIND_LOG       = 16'h7FFC;
  localparam logic [15:0] KIND_ALLOW     = 16'h7FFF;

  localparam logic [2:0] LOG_MIN_LEVEL = 3'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_t;

  typedef struct packed {
    logic [2:0]  pers;
    logic [8:0]  call;
    logic [31:0] word;
  } rule_entry_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] errno_value;
    logic        kill_request;
    logic        signal_request;
    logic        tracer_notify;
    logic        log_request;
  } result_t;

  function automatic logic kind_known(input logic [15:0] kind);
    return (kind == KIND_KILL_PROC) || (kind == KIND_KILL_THR) ||
           (kind == KIND_TRAP) || (kind == KIND_ERRNO) ||
           (kind == KIND_TRACE) || (kind == KIND_LOG) || (kind == KIND_ALLOW);
  endfunction

  // Turns the action word of a matching rule into the answer for a check.
  function automatic result_t decode_rule(input logic [31:0] word, input logic tracer,
                                          input logic [2:0] audit);
    result_t r;
    r = '0;
    r.verdict = VERDICT_ALLOW;
    if ((word[31:16] == KIND_KILL_PROC) || (word[31:16] == KIND_KILL_THR)) begin
      r.verdict = VERDICT_DENY;
      r.kill_request = 1'b1;
    end else if (word[31:16] == KIND_TRAP) begin
      r.verdict = VERDICT_DENY;
      r.signal_request = 1'b1;
    end else if (word[31:16] == KIND_ERRNO) begin
      r.verdict = VERDICT_ERRNO;
      r.errno_value = word[15:0];
    end else if (word[31:16] == KIND_TRACE) begin
      r.tracer_notify = tracer;
    end else if (word[31:16] == KIND_LOG) begin
      r.log_request = (audit >= LOG_MIN_LEVEL);
    end
    return r;
  endfunction

endpackage

// File: sv/syscall_filter_rule_table.sv
// Syscall filter rule table.
// A request is offered on start with mode, personality, call_number,
// rule_action and has_tracer, and is taken at a clock edge where start is
// high and busy is low. Mode 0 adds a rule, mode 1 checks a call.
// Every request gives exactly one result, shown for one cycle with done high:
// verdict, errno_value and the kill, signal, trace and log request flags.
// An add is answered in the cycle after it is taken and busy stays low, so
// requests may follow back to back. A check scans the stored rules newest
// first with one read of the rule memory per cycle; its result appears
// once every stored rule has been read, or sooner when a rule matches.
// The single memory read port sets this pace. busy is high while a check
// is scanning and is low again when its result is shown. The user must
// write the audit verbosity through cfg_write and cfg_data only while the
// block is idle; the block itself does not enforce this. Synchronous
// reset empties the table and sets the verbosity to 1; the rule memory is
// not cleared, as only written entries are read.
// The receiver cannot stall: done results must be taken when they appear.
module syscall_filter_rule_table #(
  parameter int RULE_DEPTH = sfrt_pkg::DEF_RULE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [2:0]  personality,
  input  logic [8:0]  call_number,
  input  logic [31:0] rule_action,
  input  logic        has_tracer,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_data,
  output logic        done,
  output logic [2:0]  verdict,
  output logic [15:0] errno_value,
  output logic        kill_request,
  output logic        signal_request,
  output logic        tracer_notify,
  output logic        log_request
);

  localparam int ADDR_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

  logic [2:0]            audit_verbosity;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  sfrt_pkg::rule_entry_t wr_entry;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  sfrt_pkg::rule_entry_t rd_entry;
  sfrt_pkg::result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      audit_verbosity <= 3'd1;
    end else if (cfg_write) begin
      audit_verbosity <= cfg_data;
    end
  end

  sfrt_rule_mem #(
    .RULE_DEPTH(RULE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  sfrt_scan #(
    .RULE_DEPTH(RULE_DEPTH)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .mode            (mode),
    .personality     (personality),
    .call_number     (call_number),
    .rule_action     (rule_action),
    .has_tracer      (has_tracer),
    .audit_verbosity (audit_verbosity),
    .busy            (busy),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_entry        (wr_entry),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_entry        (rd_entry),
    .done            (done),
    .result          (result)
  );

  assign verdict        = result.verdict;
  assign errno_value    = result.errno_value;
  assign kill_request   = result.kill_request;
  assign signal_request = result.signal_request;
  assign tracer_notify  = result.tracer_notify;
  assign log_request    = result.log_request;

  // An add is answered in the very next cycle.
  a_add_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> done)
    else $error("add request not answered in the next cycle");

  // A result is never shown while a scan is still running.
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result shown during a scan");

  // Memory writes happen only while no scan is reading the table.
  a_no_write_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy && !rd_en)
    else $error("rule write overlaps a scan");

  // Kill and signal requests come only with a deny verdict.
  a_deny_flags: assert property (@(posedge clk) disable iff (rst)
    (done && (kill_request || signal_request)) |-> (verdict == sfrt_pkg::VERDICT_DENY))
    else $error("kill or signal request without deny verdict");

endmodule

// File: sv/sfrt_rule_mem.sv
module sfrt_rule_mem #(
  parameter int RULE_DEPTH = sfrt_pkg::DEF_RULE_DEPTH,
  localparam int ADDR_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  sfrt_pkg::rule_entry_t             wr_entry,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output sfrt_pkg::rule_entry_t             rd_entry
);

  sfrt_pkg::rule_entry_t mem [RULE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

// File: sv/sfrt_scan.sv
module sfrt_scan #(
  parameter int RULE_DEPTH = sfrt_pkg::DEF_RULE_DEPTH,
  localparam int ADDR_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  mode,
  input  logic [2:0]            personality,
  input  logic [8:0]            call_number,
  input  logic [31:0]           rule_action,
  input  logic                  has_tracer,
  input  logic [2:0]            audit_verbosity,
  output logic                  busy,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output sfrt_pkg::rule_entry_t wr_entry,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  input  sfrt_pkg::rule_entry_t rd_entry,
  output logic                  done,
  output sfrt_pkg::result_t     result
);

  localparam int CNT_W = $clog2(RULE_DEPTH + 1);

  sfrt_pkg::scan_state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_m1;
  logic             pending;
  logic [2:0]       req_pers;
  logic [8:0]       req_call;
  logic             req_tracer;

  logic accept;
  logic room;
  logic pers_ok;
  logic hit;
  logic finish;

  always_comb begin
    accept = start && (state == sfrt_pkg::ST_IDLE);
    room = (count < CNT_W'(RULE_DEPTH));
    pers_ok = (32'(personality) < 32'(sfrt_pkg::NUM_PERSONALITIES));
    idx_m1 = idx - CNT_W'(1);
    hit = pending && (rd_entry.pers == req_pers) && (rd_entry.call == req_call) &&
          sfrt_pkg::kind_known(rd_entry.word[31:16]);

    wr_en = accept && !mode && room && pers_ok;
    wr_addr = count[ADDR_W-1:0];
    wr_entry.pers = personality;
    wr_entry.call = call_number;
    wr_entry.word = rule_action;

    rd_en = 1'b0;
    finish = 1'b0;
    state_next = state;
    unique case (state)
      sfrt_pkg::ST_IDLE: begin
        if (accept && mode) begin
          state_next = sfrt_pkg::ST_SCAN;
        end
      end
      sfrt_pkg::ST_SCAN: begin
        // While older entries remain, a read is kept in flight every cycle; the entry
        // read last cycle is compared while the next older one is fetched.
        if (hit || ((idx == '0) && !pending)) begin
          finish = 1'b1;
          state_next = sfrt_pkg::ST_IDLE;
        end else if (idx != '0) begin
          rd_en = 1'b1;
        end
      end
      default: state_next = sfrt_pkg::ST_IDLE;
    endcase
    rd_addr = idx_m1[ADDR_W-1:0];
    busy = (state != sfrt_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfrt_pkg::ST_IDLE;
      count <= '0;
      pending <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      pending <= rd_en;
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      done <= (accept && !mode) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= count;
      req_pers <= personality;
      req_call <= call_number;
      req_tracer <= has_tracer;
    end else if (rd_en) begin
      idx <= idx_m1;
    end

    if (accept && !mode) begin
      result <= '0;
      result.verdict <= (room && pers_ok) ? sfrt_pkg::VERDICT_ADDED : sfrt_pkg::VERDICT_FULL;
    end else if (finish) begin
      if (hit) begin
        result <= sfrt_pkg::decode_rule(rd_entry.word, req_tracer, audit_verbosity);
      end else begin
        result <= '0;
        result.verdict <= sfrt_pkg::VERDICT_ALLOW;
      end
    end
  end

endmodule
